FILE: hdl/srs_pkg.sv
// ----------------------------------------------------------------------------
// Sparse recovery sketch package
// Shared cell layout, hash constants and multiply-accumulate shift codes.
// ----------------------------------------------------------------------------
package srs_pkg;

    // Widths fixed by the item fields and the cell counters.
    localparam int KEY_W    = 24;
    localparam int OUT_KEY_W = 20;
    localparam int W_W      = 32;
    localparam int IO_W     = 56;
    localparam int SQ_W     = 64;
    localparam int CFG_W    = 30;
    localparam int CFG_ROWS = 4;
    localparam int ACC_W    = 128;
    localparam int DIV_STEPS = 56;

    // Hash prime; its 2^30 residue is applied in the fold logic of the unit.
    localparam logic [30:0] HASH_PRIME = 31'd1073741789;

    // One sketch cell as stored in memory.
    typedef struct packed {
        logic [W_W-1:0]  weight;
        logic [IO_W-1:0] index;
        logic [SQ_W-1:0] square;
    } cell_t;

    // Left shift applied to a partial product before accumulation.
    typedef enum logic [1:0] {
        SH_0  = 2'd0,
        SH_32 = 2'd1,
        SH_33 = 2'd2,
        SH_64 = 2'd3
    } mac_shift_t;

endpackage

FILE: hdl/sparse_recovery_sketch_unit.sv
// Update item: in_ready stays low from acceptance until the last row is written back;
// the shared multiplier is used for the key square and three times per row.
// Probe item: its result waits on the five partial products of the verify step and,
// when the cell holds one key, on the bit-serial divider.
// One item at a time. After reset a clearing pass writes ROWS*COLS cells, one per
// cycle (1024 cells by default), before the first item is accepted.
// ----------------------------------------------------------------------------
// Sparse recovery sketch unit
// Linear s-sparse recovery sketch with hashed updates and one-sparse probes,
// run by a small sequencer around one shared multiplier.
// ----------------------------------------------------------------------------
module sparse_recovery_sketch_unit
    import srs_pkg::*;
#(
    parameter int ROWS     = 4,
    parameter int COLS     = 256,
    parameter int KEY_BITS = 20
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [2:0]                  cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        kind,
    input  logic [19:0]                 item_key,
    input  logic signed [1:0]           change,
    input  logic [7:0]                  probe_col,
    input  logic [1:0]                  probe_row,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        one_sparse,
    output logic [OUT_KEY_W-1:0]        recovered_key,
    output logic signed [W_W-1:0]       cell_weight
);

    localparam int DEPTH     = ROWS * COLS;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int COL_BITS  = $clog2(COLS);
    localparam logic [63:0] RECIP_WIDE = (64'd1 << 32) / COLS;
    localparam logic [31:0] RECIP      = RECIP_WIDE[31:0];
    localparam logic [63:0] KEY_MASK_WIDE = (64'd1 << KEY_BITS) - 64'd1;
    localparam logic [KEY_W-1:0] KEY_MASK = KEY_MASK_WIDE[KEY_W-1:0];

    typedef enum logic [17:0] {
        ST_CLEAR = 18'h00001,
        ST_IDLE  = 18'h00002,
        ST_KSQ   = 18'h00004,
        ST_HMUL  = 18'h00008,
        ST_HFOLD = 18'h00010,
        ST_HMOD  = 18'h00020,
        ST_CMUL  = 18'h00040,
        ST_CQ    = 18'h00080,
        ST_CREM  = 18'h00100,
        ST_URD   = 18'h00200,
        ST_UWR   = 18'h00400,
        ST_PRD   = 18'h00800,
        ST_PLOAD = 18'h01000,
        ST_PMUL  = 18'h02000,
        ST_PACC  = 18'h04000,
        ST_PCHK  = 18'h08000,
        ST_PDIV  = 18'h10000,
        ST_POUT  = 18'h20000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [CFG_W-1:0] mult_reg [CFG_ROWS];
    logic [CFG_W-1:0] off_reg  [CFG_ROWS];

    // Sequencer and datapath registers.
    logic [ADDR_BITS-1:0] clr_reg, clr_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [ADDR_BITS-1:0] base_reg, base_next;
    logic [1:0]           row_reg, row_next;
    logic [2:0]           step_reg, step_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [1:0]           chg_reg, chg_next;
    logic [2*KEY_W-1:0]   ksq_reg, ksq_next;
    logic [31:0]          fold_reg, fold_next;
    logic [29:0]          hv_reg, hv_next;
    logic [W_W-1:0]       w_reg, w_next;
    logic [W_W-1:0]       wmag_reg, wmag_next;
    logic [IO_W-1:0]      iomag_reg, iomag_next;
    logic [SQ_W-1:0]      taumag_reg, taumag_next;
    logic                 wneg_reg, wneg_next;
    logic                 ioneg_reg, ioneg_next;
    logic                 tauneg_reg, tauneg_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic                 mac_en_reg, mac_en_next;
    logic                 mac_sub_reg, mac_sub_next;
    mac_shift_t           mac_sh_reg, mac_sh_next;
    logic                 hit_reg, hit_next;
    logic [OUT_KEY_W-1:0] rkey_reg, rkey_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_hit_reg, out_hit_next;
    logic [OUT_KEY_W-1:0] out_key_reg, out_key_next;
    logic [W_W-1:0]       out_w_reg, out_w_next;

    // Shared multiplier, store and divider connections.
    logic [31:0]          mul_a, mul_b;
    logic [63:0]          product;
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    cell_t                wr_data;
    cell_t                rd_data;
    logic                 div_start;
    logic                 div_done;
    logic [OUT_KEY_W-1:0] div_quo;

    // Combinational helpers.
    logic [54:0]          hsum;
    logic [24:0]          hhi;
    logic [30:0]          hred;
    logic [31:0]          crem;
    logic [31:0]          ccol;
    logic [IO_W-1:0]      io_term;
    logic [SQ_W-1:0]      sq_term;
    logic [W_W-1:0]       w_term;
    logic [ACC_W-1:0]     pp_ext;
    logic [ACC_W-1:0]     pp_shift;
    logic [31:0]          paddr;
    logic                 prange;

    srs_mul u_mul (
        .clk     (clk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (product)
    );

    srs_store #(
        .DEPTH     (DEPTH),
        .ADDR_BITS (ADDR_BITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    srs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (iomag_reg),
        .divisor  (wmag_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Configuration writes, taken at any time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_ROWS; i++)
            begin
                mult_reg[i] <= '0;
                off_reg[i]  <= '0;
            end
        end
        else if (cfg_write)
        begin
            if (cfg_index[0])
            begin
                off_reg[cfg_index[2:1]] <= cfg_data;
            end
            else
            begin
                mult_reg[cfg_index[2:1]] <= cfg_data;
            end
        end
    end

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_KSQ:
            begin
                mul_a = 32'(key_reg);
                mul_b = 32'(key_reg);
            end
            ST_HMUL:
            begin
                mul_a = 32'(mult_reg[row_reg]);
                mul_b = 32'(key_reg);
            end
            ST_CMUL:
            begin
                mul_a = 32'(hv_reg);
                mul_b = RECIP;
            end
            ST_CQ:
            begin
                mul_a = product[63:32];
                mul_b = 32'(COLS);
            end
            ST_PMUL:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        mul_a = iomag_reg[31:0];
                        mul_b = iomag_reg[31:0];
                    end
                    3'd1:
                    begin
                        mul_a = iomag_reg[31:0];
                        mul_b = 32'(iomag_reg[IO_W-1:32]);
                    end
                    3'd2:
                    begin
                        mul_a = 32'(iomag_reg[IO_W-1:32]);
                        mul_b = 32'(iomag_reg[IO_W-1:32]);
                    end
                    3'd3:
                    begin
                        mul_a = wmag_reg;
                        mul_b = taumag_reg[31:0];
                    end
                    default:
                    begin
                        mul_a = wmag_reg;
                        mul_b = taumag_reg[63:32];
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Hash reduction, column remainder and probe address arithmetic.
    always_comb
    begin
        hsum   = product[54:0] + 55'(off_reg[row_reg]);
        hhi    = hsum[54:30];
        hred   = 31'({fold_reg[31:30], 5'b0}) + 31'({fold_reg[31:30], 1'b0})
                 + 31'(fold_reg[31:30]) + 31'(fold_reg[29:0]);
        crem   = 32'(hv_reg) - product[31:0];
        ccol   = (crem >= 32'(COLS)) ? crem - 32'(COLS) : crem;
        paddr  = (32'(probe_row) * 32'(COLS)) + 32'(probe_col);
        prange = (32'(probe_row) < 32'(ROWS)) && (32'(probe_col) < 32'(COLS));
    end

    // Signed update terms: change, change times key and change times key squared.
    always_comb
    begin
        case (chg_reg)
            2'b01:
            begin
                w_term  = 32'd1;
                io_term = IO_W'(key_reg);
                sq_term = SQ_W'(ksq_reg);
            end
            2'b11:
            begin
                w_term  = '1;
                io_term = -IO_W'(key_reg);
                sq_term = -SQ_W'(ksq_reg);
            end
            2'b10:
            begin
                w_term  = 32'hFFFF_FFFE;
                io_term = -(IO_W'(key_reg) << 1);
                sq_term = -(SQ_W'(ksq_reg) << 1);
            end
            default:
            begin
                w_term  = '0;
                io_term = '0;
                sq_term = '0;
            end
        endcase
    end

    // Shifted partial product for the verify accumulator.
    always_comb
    begin
        pp_ext = ACC_W'(product);
        case (mac_sh_reg)
            SH_32:   pp_shift = pp_ext << 32;
            SH_33:   pp_shift = pp_ext << 33;
            SH_64:   pp_shift = pp_ext << 64;
            default: pp_shift = pp_ext;
        endcase
    end

    // Store write port: clearing pass or cell update.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = '0;
        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
        end
        else if (state_reg == ST_UWR)
        begin
            wr_en          = 1'b1;
            wr_data.weight = rd_data.weight + w_term;
            wr_data.index  = rd_data.index + io_term;
            wr_data.square = rd_data.square + sq_term;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        addr_next      = addr_reg;
        base_next      = base_reg;
        row_next       = row_reg;
        step_next      = step_reg;
        key_next       = key_reg;
        chg_next       = chg_reg;
        ksq_next       = ksq_reg;
        fold_next      = fold_reg;
        hv_next        = hv_reg;
        w_next         = w_reg;
        wmag_next      = wmag_reg;
        iomag_next     = iomag_reg;
        taumag_next    = taumag_reg;
        wneg_next      = wneg_reg;
        ioneg_next     = ioneg_reg;
        tauneg_next    = tauneg_reg;
        acc_next       = acc_reg;
        mac_en_next    = 1'b0;
        mac_sub_next   = mac_sub_reg;
        mac_sh_next    = mac_sh_reg;
        hit_next       = hit_reg;
        rkey_next      = rkey_reg;
        out_valid_next = out_valid_reg;
        out_hit_next   = out_hit_reg;
        out_key_next   = out_key_reg;
        out_w_next     = out_w_reg;
        div_start      = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Accumulate the partial product issued in the previous cycle.
        if (mac_en_reg)
        begin
            acc_next = mac_sub_reg ? acc_reg - pp_shift : acc_reg + pp_shift;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_BITS'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    key_next  = KEY_W'(item_key) & KEY_MASK;
                    chg_next  = change;
                    row_next  = 2'd0;
                    base_next = '0;
                    if (!kind)
                    begin
                        state_next = ST_KSQ;
                    end
                    else if (prange)
                    begin
                        addr_next  = paddr[ADDR_BITS-1:0];
                        state_next = ST_PRD;
                    end
                    else
                    begin
                        // Probe outside the store answers as an empty cell.
                        w_next     = '0;
                        hit_next   = 1'b0;
                        rkey_next  = '0;
                        state_next = ST_POUT;
                    end
                end
            end
            ST_KSQ:
            begin
                state_next = ST_HMUL;
            end
            ST_HMUL:
            begin
                if (row_reg == 2'd0)
                begin
                    ksq_next = product[2*KEY_W-1:0];
                end
                state_next = ST_HFOLD;
            end
            ST_HFOLD:
            begin
                // First fold: 2^30 is 35 modulo the prime.
                fold_next  = 32'({hhi, 5'b0}) + 32'({hhi, 1'b0}) + 32'(hhi)
                             + 32'(hsum[29:0]);
                state_next = ST_HMOD;
            end
            ST_HMOD:
            begin
                hv_next    = (hred >= HASH_PRIME) ? 30'(hred - HASH_PRIME) : hred[29:0];
                state_next = ST_CMUL;
            end
            ST_CMUL:
            begin
                state_next = ST_CQ;
            end
            ST_CQ:
            begin
                state_next = ST_CREM;
            end
            ST_CREM:
            begin
                addr_next  = base_reg + ADDR_BITS'(ccol[COL_BITS-1:0]);
                state_next = ST_URD;
            end
            ST_URD:
            begin
                state_next = ST_UWR;
            end
            ST_UWR:
            begin
                if (row_reg == 2'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    row_next   = row_reg + 2'd1;
                    base_next  = base_reg + ADDR_BITS'(COLS);
                    state_next = ST_HMUL;
                end
            end
            ST_PRD:
            begin
                state_next = ST_PLOAD;
            end
            ST_PLOAD:
            begin
                w_next      = rd_data.weight;
                wneg_next   = rd_data.weight[W_W-1];
                ioneg_next  = rd_data.index[IO_W-1];
                tauneg_next = rd_data.square[SQ_W-1];
                wmag_next   = rd_data.weight[W_W-1] ? -rd_data.weight : rd_data.weight;
                iomag_next  = rd_data.index[IO_W-1] ? -rd_data.index : rd_data.index;
                taumag_next = rd_data.square[SQ_W-1] ? -rd_data.square : rd_data.square;
                acc_next    = '0;
                step_next   = 3'd0;
                state_next  = ST_PMUL;
            end
            ST_PMUL:
            begin
                // Index square is added, weight times square sum subtracted.
                mac_en_next = 1'b1;
                case (step_reg)
                    3'd0:
                    begin
                        mac_sub_next = 1'b0;
                        mac_sh_next  = SH_0;
                    end
                    3'd1:
                    begin
                        mac_sub_next = 1'b0;
                        mac_sh_next  = SH_33;
                    end
                    3'd2:
                    begin
                        mac_sub_next = 1'b0;
                        mac_sh_next  = SH_64;
                    end
                    3'd3:
                    begin
                        mac_sub_next = 1'b1;
                        mac_sh_next  = SH_0;
                    end
                    default:
                    begin
                        mac_sub_next = 1'b1;
                        mac_sh_next  = SH_32;
                    end
                endcase
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd4)
                begin
                    state_next = ST_PACC;
                end
            end
            ST_PACC:
            begin
                state_next = ST_PCHK;
            end
            ST_PCHK:
            begin
                rkey_next = '0;
                if ((w_reg != '0) && (acc_reg == '0)
                    && !((wneg_reg != tauneg_reg) && (taumag_reg != '0)))
                begin
                    hit_next   = 1'b1;
                    div_start  = 1'b1;
                    state_next = ST_PDIV;
                end
                else
                begin
                    hit_next   = 1'b0;
                    state_next = ST_POUT;
                end
            end
            ST_PDIV:
            begin
                if (div_done)
                begin
                    rkey_next  = (ioneg_reg != wneg_reg) ? -div_quo : div_quo;
                    state_next = ST_POUT;
                end
            end
            ST_POUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = hit_reg;
                    out_key_next   = rkey_reg;
                    out_w_next     = w_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            row_reg       <= 2'd0;
            step_reg      <= 3'd0;
            mac_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            row_reg       <= row_next;
            step_reg      <= step_next;
            mac_en_reg    <= mac_en_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        base_reg    <= base_next;
        key_reg     <= key_next;
        chg_reg     <= chg_next;
        ksq_reg     <= ksq_next;
        fold_reg    <= fold_next;
        hv_reg      <= hv_next;
        w_reg       <= w_next;
        wmag_reg    <= wmag_next;
        iomag_reg   <= iomag_next;
        taumag_reg  <= taumag_next;
        wneg_reg    <= wneg_next;
        ioneg_reg   <= ioneg_next;
        tauneg_reg  <= tauneg_next;
        acc_reg     <= acc_next;
        mac_sub_reg <= mac_sub_next;
        mac_sh_reg  <= mac_sh_next;
        hit_reg     <= hit_next;
        rkey_reg    <= rkey_next;
        out_hit_reg <= out_hit_next;
        out_key_reg <= out_key_next;
        out_w_reg   <= out_w_next;
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign one_sparse    = out_hit_reg;
    assign recovered_key = out_key_reg;
    assign cell_weight   = out_w_reg;

endmodule

FILE: hdl/srs_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned 32 by 32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module srs_mul (
    input  logic        clk,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] product
);

    logic [63:0] product_reg;

    // The product is registered and appears in the cycle after the operands are presented.
    always_ff @(posedge clk)
    begin
        product_reg <= 64'(op_a) * 64'(op_b);
    end

    assign product = product_reg;

endmodule

FILE: hdl/srs_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring division of a 56-bit magnitude by a 32-bit magnitude, one
// quotient bit per cycle; only the low 20 quotient bits are kept.
// ----------------------------------------------------------------------------
module srs_div
    import srs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [IO_W-1:0]      dividend,
    input  logic [W_W-1:0]       divisor,
    output logic                 done,
    output logic [OUT_KEY_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic [IO_W-1:0]      num_reg, num_next;
    logic [W_W-1:0]       den_reg, den_next;
    logic [W_W-1:0]       rem_reg, rem_next;
    logic [OUT_KEY_W-1:0] quo_reg, quo_next;
    logic [W_W:0]         trial;

    // One restoring step per cycle while busy.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        trial     = {rem_reg, num_reg[IO_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[IO_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = W_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[OUT_KEY_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[W_W-1:0];
                quo_next = {quo_reg[OUT_KEY_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: hdl/srs_store.sv
// ----------------------------------------------------------------------------
// Sketch cell store
// Single-port-write, single-port-read memory of sketch cells with a
// registered read.
// ----------------------------------------------------------------------------
module srs_store
    import srs_pkg::*;
#(
    parameter int DEPTH     = 1024,
    parameter int ADDR_BITS = 10
)
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  cell_t                wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output cell_t                rd_data
);

    cell_t mem [DEPTH];
    cell_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: tb/sparse_recovery_sketch_checker.sv
// ----------------------------------------------------------------------------
// Sparse recovery sketch checker
// Watches both item channels and keeps its own copy of the hash terms and the
// cell sums. Each accepted probe item queues the expected result, and each
// accepted result is compared field by field with the oldest one queued.
// ----------------------------------------------------------------------------
module sparse_recovery_sketch_checker
    import srs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic                  kind,
    input  logic [19:0]           item_key,
    input  logic signed [1:0]     change,
    input  logic [7:0]            probe_col,
    input  logic [1:0]            probe_row,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic                  one_sparse,
    input  logic [OUT_KEY_W-1:0]  recovered_key,
    input  logic signed [W_W-1:0] cell_weight,
    output int                    fail_count,
    output int                    pending_count,
    output int                    probe_count,
    output int                    hit_count
);

    localparam int NROWS = 4;
    localparam int NCOLS = 256;
    localparam logic ITEM_PROBE = 1'b1;

    typedef struct packed {
        logic                  sparse;
        logic [OUT_KEY_W-1:0]  key;
        logic [W_W-1:0]        weight;
    } probe_result_t;

    logic [CFG_W-1:0] hash_mult [NROWS];
    logic [CFG_W-1:0] hash_add  [NROWS];
    logic [W_W-1:0]   wsum [NROWS*NCOLS];
    logic [IO_W-1:0]  isum [NROWS*NCOLS];
    logic [SQ_W-1:0]  ssum [NROWS*NCOLS];
    probe_result_t    expected_results [$];

    assign pending_count = expected_results.size();

    // Column picked by one row for a key.
    function automatic int hash_column(int r, logic [19:0] key);
        logic [63:0] t;
        t = 64'(hash_mult[r]) * 64'(key) + 64'(hash_add[r]);
        return int'((t % 64'(HASH_PRIME)) % NCOLS);
    endfunction

    // Add a signed change to one cell per row.
    task automatic apply_update(logic [19:0] key, logic signed [1:0] d);
        int c;
        logic signed [63:0] dw;
        dw = 64'(d);
        for (int r = 0; r < NROWS; r++)
        begin
            c = r * NCOLS + hash_column(r, key);
            wsum[c] = wsum[c] + W_W'(dw);
            isum[c] = isum[c] + IO_W'(dw * $signed({44'd0, key}));
            ssum[c] = ssum[c] + dw * $signed({44'd0, key}) * $signed({44'd0, key});
        end
    endtask

    // Exact one-sparse test over full widths and recovered key.
    function automatic probe_result_t probe_cell(logic [7:0] col, logic [1:0] row);
        probe_result_t res;
        logic signed [IO_W-1:0] io;
        logic signed [W_W-1:0]  w;
        logic signed [SQ_W-1:0] sq;
        logic signed [127:0]    lhs, rhs;
        logic [63:0]            qmag, io_mag, w_mag;
        int c;
        res = '0;
        c = int'(row) * NCOLS + int'(col);
        w = wsum[c];
        io = isum[c];
        sq = ssum[c];
        lhs = 128'(io) * 128'(io);
        rhs = 128'(w) * 128'(sq);
        res.weight = w;
        if (w != 0 && lhs == rhs)
        begin
            res.sparse = 1'b1;
            io_mag = io < 0 ? 64'(-128'(io)) : 64'(io);
            w_mag = w < 0 ? 64'(-64'(w)) : 64'(w);
            qmag = io_mag / w_mag;
            if ((io < 0) != (w < 0))
                qmag = -qmag;
            res.key = qmag[OUT_KEY_W-1:0];
        end
        return res;
    endfunction

    // Predict on accepted items and compare accepted results.
    always @(posedge clk or negedge rst_n)
    begin
        probe_result_t want;
        int errs;
        if (!rst_n)
        begin
            fail_count <= 0;
            probe_count <= 0;
            hit_count <= 0;
            expected_results.delete();
            for (int r = 0; r < NROWS; r++)
            begin
                hash_mult[r] = '0;
                hash_add[r] = '0;
            end
            for (int i = 0; i < NROWS*NCOLS; i++)
            begin
                wsum[i] = '0;
                isum[i] = '0;
                ssum[i] = '0;
            end
        end
        else
        begin
            errs = 0;
            if (cfg_write)
            begin
                if (cfg_index[0])
                    hash_add[cfg_index[2:1]] = cfg_data;
                else
                    hash_mult[cfg_index[2:1]] = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                if (kind == ITEM_PROBE)
                begin
                    expected_results = {expected_results, probe_cell(probe_col, probe_row)};
                    probe_count <= probe_count + 1;
                end
                else
                    apply_update(item_key, change);
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no expectation waiting");
                    errs = errs + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.sparse) hit_count <= hit_count + 1;
                    if (one_sparse !== want.sparse)
                    begin
                        $error("one_sparse: expected %0d, actual %0d", want.sparse, one_sparse);
                        errs = errs + 1;
                    end
                    if (recovered_key !== want.key)
                    begin
                        $error("recovered_key: expected %0d, actual %0d",
                               want.key, recovered_key);
                        errs = errs + 1;
                    end
                    if (cell_weight !== want.weight)
                    begin
                        $error("cell_weight: expected %0d, actual %0d",
                               $signed(want.weight), cell_weight);
                        errs = errs + 1;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end

endmodule

FILE: tb/sparse_recovery_sketch_unit_tb.sv
// ----------------------------------------------------------------------------
// Sparse recovery sketch testbench
// Drives hash settings, update and probe items with random idling on both
// sides; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module sparse_recovery_sketch_unit_tb
    import srs_pkg::*;
();

    localparam logic ITEM_UPDATE = 1'b0;
    localparam logic ITEM_PROBE  = 1'b1;
    localparam int   CYCLE_LIMIT = 900000;
    localparam logic [CFG_W-1:0] TERM_MAX = 30'd1073741788;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic kind = 1'b0;
    logic [19:0] item_key = '0;
    logic signed [1:0] change = '0;
    logic [7:0] probe_col = '0;
    logic [1:0] probe_row = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic one_sparse;
    logic [OUT_KEY_W-1:0] recovered_key;
    logic signed [W_W-1:0] cell_weight;
    int fail_count, pending_count, probe_count, hit_count;
    int cycle_count = 0;
    bit no_idle = 1'b0;
    logic [19:0] live_keys [$];

    always #5 clk = ~clk;

    sparse_recovery_sketch_unit DUT (.*);
    sparse_recovery_sketch_checker checker_i (.*);

    // Receiver stalls at random, never during the quiet stretch.
    always @(posedge clk)
        out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 36);

    // Overall limit on the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Hand one item to the block, with a random gap in front. Valid stays high
    // after acceptance so that a following item can go out with no gap.
    task automatic send_item(logic k, logic [19:0] key, logic signed [1:0] d,
                             logic [7:0] col, logic [1:0] row);
        bit gap;
        gap = !no_idle && ($urandom_range(99) < 36);
        if (gap)
            in_valid <= 1'b0;
        while (gap)
        begin
            @(posedge clk);
            gap = !no_idle && ($urandom_range(99) < 36);
        end
        kind <= k;
        item_key <= key;
        change <= d;
        probe_col <= col;
        probe_row <= row;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_term(logic [2:0] idx, logic [CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    // One setting for all eight hash terms.
    task automatic load_hash(int mode);
        logic [CFG_W-1:0] v;
        for (int i = 0; i < 8; i++)
        begin
            case (mode)
                0: v = '0;
                1: v = TERM_MAX;
                2: v = '1;
                default: v = CFG_W'($urandom_range(TERM_MAX));
            endcase
            write_term(3'(i), v);
        end
        cfg_write <= 1'b0;
    endtask

    // Insert a key; every live key is tracked so deletions match inserts.
    task automatic insert_key(logic [19:0] key);
        send_item(ITEM_UPDATE, key, 2'sd1, 8'd0, 2'd0);
        live_keys = {live_keys, key};
    endtask

    task automatic random_phase(int n);
        int sel, idx;
        logic [19:0] key;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 30 || live_keys.size() == 0)
            begin
                key = ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(15));
                insert_key(key);
            end
            else if (sel < 50)
            begin
                idx = $urandom_range(live_keys.size() - 1);
                send_item(ITEM_UPDATE, live_keys[idx], -2'sd1, 8'd0, 2'd0);
                live_keys.delete(idx);
            end
            else if (sel < 55)
                send_item(ITEM_UPDATE, 20'($urandom), 2'($urandom), 8'($urandom),
                          2'($urandom));
            else
                send_item(ITEM_PROBE, 20'($urandom), 2'($urandom), 8'($urandom),
                          2'($urandom));
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under all-zero terms: everything lands in column 0.
        insert_key(20'hFFFFF);
        send_item(ITEM_PROBE, 20'd0, 2'sd0, 8'd0, 2'd0);
        send_item(ITEM_PROBE, 20'd0, 2'sd0, 8'd255, 2'd3);
        send_item(ITEM_UPDATE, 20'd7, -2'sd2, 8'd0, 2'd0);
        send_item(ITEM_PROBE, 20'd0, 2'sd0, 8'd0, 2'd1);
        send_item(ITEM_UPDATE, 20'd7, 2'sd0, 8'd0, 2'd0);
        send_item(ITEM_UPDATE, 20'd0, -2'sd1, 8'd0, 2'd0);
        send_item(ITEM_PROBE, 20'd0, 2'sd0, 8'd0, 2'd2);
        send_item(ITEM_UPDATE, 20'd7, 2'sd1, 8'd0, 2'd0);
        send_item(ITEM_UPDATE, 20'd7, 2'sd1, 8'd0, 2'd0);
        send_item(ITEM_PROBE, 20'd0, 2'sd0, 8'd0, 2'd3);
        send_item(ITEM_UPDATE, 20'hFFFFF, -2'sd1, 8'd0, 2'd0);
        send_item(ITEM_PROBE, 20'd0, 2'sd0, 8'd0, 2'd0);
        wait_drained();

        // Settings: all at the top of range, all ones, then random ones.
        for (int phase = 1; phase < 8; phase++)
        begin
            load_hash(phase < 3 ? phase : 3);
            no_idle = (phase == 4);
            random_phase(270);
            wait_drained();
        end
        no_idle = 1'b0;

        $display("Covered %0d probe items, %0d of them on one-sparse cells,",
                 probe_count, hit_count);
        $display("over eight hash settings including all-zero and all-ones terms.");
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
